>>> hw/rtl/cia_pkg.sv
`default_nettype none
package cia_pkg;

   typedef logic [4:0] opcode_type;
   typedef logic [2:0] error_type;

   localparam opcode_type OP_ADD  = 5'd0;
   localparam opcode_type OP_SUB  = 5'd1;
   localparam opcode_type OP_MUL  = 5'd2;
   localparam opcode_type OP_DIV  = 5'd3;
   localparam opcode_type OP_MOD  = 5'd4;
   localparam opcode_type OP_SHL  = 5'd5;
   localparam opcode_type OP_SHR  = 5'd6;
   localparam opcode_type OP_AND  = 5'd12;
   localparam opcode_type OP_XOR  = 5'd13;
   localparam opcode_type OP_OR   = 5'd14;
   localparam opcode_type OP_LAND = 5'd15;
   localparam opcode_type OP_LOR  = 5'd16;

   localparam error_type ERR_OK       = 3'd0;
   localparam error_type ERR_OVERFLOW = 3'd1;
   localparam error_type ERR_DIVZERO  = 3'd2;
   localparam error_type ERR_SHIFT    = 3'd3;
   localparam error_type ERR_OPCODE   = 3'd4;

endpackage
`default_nettype wire

>>> hw/rtl/cia_divider.sv
`default_nettype none
module cia_divider import cia_pkg::*; #(
   parameter int W = 64
) (
   input  wire logic         clock,
   input  wire logic [W-1:0] dividend,
   input  wire logic [W-1:0] divisor,
   output logic      [W-1:0] quotient,
   output logic      [W-1:0] remainder
);

   // one restoring step per stage, magnitudes only
   logic [W-1:0] rem_ff [W+1];
   logic [W-1:0] dvd_ff [W+1];
   logic [W-1:0] dsr_ff [W+1];

   always_ff @(posedge clock) begin
      rem_ff[0] <= '0;
      dvd_ff[0] <= dividend[W-1] ? (~dividend + 1'b1) : dividend;
      dsr_ff[0] <= divisor[W-1] ? (~divisor + 1'b1) : divisor;
   end

   for (genvar k = 0; k < W; k++) begin : g_step
      logic [W:0]   trial;
      logic [W:0]   diff;
      logic [W-1:0] rem_in;
      logic [W-1:0] dvd_in;

      always_comb begin
         trial  = {rem_ff[k], dvd_ff[k][W-1]};
         diff   = trial - {1'b0, dsr_ff[k]};
         rem_in = diff[W] ? trial[W-1:0] : diff[W-1:0];
         dvd_in = {dvd_ff[k][W-2:0], ~diff[W]};
      end

      always_ff @(posedge clock) begin
         rem_ff[k+1] <= rem_in;
         dvd_ff[k+1] <= dvd_in;
         dsr_ff[k+1] <= dsr_ff[k];
      end
   end

   assign quotient  = dvd_ff[W];
   assign remainder = rem_ff[W];

endmodule
`default_nettype wire

>>> hw/rtl/cia_multiplier.sv
`default_nettype none
module cia_multiplier import cia_pkg::*; #(
   parameter int W = 64
) (
   input  wire logic         clock,
   input  wire logic [W-1:0] lhs,
   input  wire logic [W-1:0] rhs,
   output logic      [W-1:0] product,
   output logic              overflow
);

   localparam int L = (W + 1) / 2;
   localparam int U = W - L;

   logic [W-1:0]   ma_ff, mb_ff;
   logic           neg1_ff, neg2_ff, neg3_ff;
   logic [2*L-1:0] pp00_ff;
   logic [L+U-1:0] pp01_ff, pp10_ff;
   logic [2*U-1:0] pp11_ff;
   logic [2*W-1:0] prod_ff;
   logic [W-1:0]   res_ff;
   logic           ovf_ff;
   logic [W-1:0]   lo;
   logic           ovf_in;

   always_ff @(posedge clock) begin
      ma_ff   <= lhs[W-1] ? (~lhs + 1'b1) : lhs;
      mb_ff   <= rhs[W-1] ? (~rhs + 1'b1) : rhs;
      neg1_ff <= lhs[W-1] ^ rhs[W-1];

      pp00_ff <= ma_ff[L-1:0] * mb_ff[L-1:0];
      pp01_ff <= ma_ff[L-1:0] * mb_ff[W-1:L];
      pp10_ff <= ma_ff[W-1:L] * mb_ff[L-1:0];
      pp11_ff <= ma_ff[W-1:L] * mb_ff[W-1:L];
      neg2_ff <= neg1_ff;

      prod_ff <= (2*W)'(pp00_ff) + ((2*W)'(pp01_ff) << L) + ((2*W)'(pp10_ff) << L)
               + ((2*W)'(pp11_ff) << (2*L));
      neg3_ff <= neg2_ff;

      res_ff  <= ovf_in ? '0 : (neg3_ff ? (~lo + 1'b1) : lo);
      ovf_ff  <= ovf_in;
   end

   always_comb begin
      lo     = prod_ff[W-1:0];
      ovf_in = (prod_ff[2*W-1:W] != '0) ||
               (neg3_ff ? (lo[W-1] && (lo[W-2:0] != '0)) : lo[W-1]);
   end

   assign product  = res_ff;
   assign overflow = ovf_ff;

endmodule
`default_nettype wire

>>> hw/rtl/checked_integer_alu.sv
// Checked integer ALU. One item may be started in every cycle; busy stays low.
// Each item gives exactly one result in start order, strobed on rsp_strobe
// once it has passed the input registers, the pipeline and the output
// register. The depth is set by the divider, which resolves one quotient bit
// per pipeline stage; every operation goes through the same depth. The
// receiver cannot stall results, so it must take rsp_* whenever rsp_strobe
// is high. On any error the result is zero and rsp_error_code names the error.
`default_nettype none
module checked_integer_alu import cia_pkg::*; #(
   parameter int DATA_WIDTH = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic        [4:0]  req_opcode,
   input  wire logic signed [63:0] req_lhs_value,
   input  wire logic signed [63:0] req_rhs_value,
   output logic                    rsp_strobe,
   output logic signed      [63:0] rsp_result_value,
   output logic             [2:0]  rsp_error_code
);

   localparam int W    = DATA_WIDTH;
   localparam int SHW  = $clog2(W);
   localparam int MDLY = W - 3;

   typedef struct packed {
      opcode_type   op;
      logic         neg_q;
      logic         neg_r;
      logic         dz;
      logic [W-1:0] res;
      error_type    err;
   } tag_type;

   logic             s0_vld_ff;
   opcode_type       s0_op_ff;
   logic [W-1:0]     s0_a_ff, s0_b_ff;
   logic [W:0]       vld_ff;
   tag_type          tag_ff [W+1];
   tag_type          tag_in;
   logic [W:0]       mul_ff [MDLY];
   logic [W-1:0]     mul_res;
   logic             mul_ovf;
   logic [W-1:0]     quo, rmd;
   logic [W-1:0]     sum, dif;
   logic [W-1:0]     fin_res;
   error_type        fin_err;
   tag_type          tg;
   logic             rsp_strobe_ff;
   logic [63:0]      rsp_res_ff;
   error_type        rsp_err_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff     <= 1'b0;
         vld_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         s0_vld_ff     <= start && !busy;
         vld_ff        <= {vld_ff[W-1:0], s0_vld_ff};
         rsp_strobe_ff <= vld_ff[W];
      end
   end

   always_ff @(posedge clock) begin
      s0_op_ff <= req_opcode;
      s0_a_ff  <= req_lhs_value[W-1:0];
      s0_b_ff  <= req_rhs_value[W-1:0];
   end

   cia_divider #(.W(W)) u_div (
      .clock     (clock),
      .dividend  (s0_a_ff),
      .divisor   (s0_b_ff),
      .quotient  (quo),
      .remainder (rmd)
   );

   cia_multiplier #(.W(W)) u_mul (
      .clock    (clock),
      .lhs      (s0_a_ff),
      .rhs      (s0_b_ff),
      .product  (mul_res),
      .overflow (mul_ovf)
   );

   // combinational ops, plus the tag for the pipelined ops
   always_comb begin
      sum          = s0_a_ff + s0_b_ff;
      dif          = s0_a_ff - s0_b_ff;
      tag_in.op    = s0_op_ff;
      tag_in.neg_q = s0_a_ff[W-1] ^ s0_b_ff[W-1];
      tag_in.neg_r = s0_a_ff[W-1];
      tag_in.dz    = (s0_b_ff == '0);
      tag_in.res   = '0;
      tag_in.err   = ERR_OK;
      case (s0_op_ff)
         OP_ADD: begin
            if (s0_a_ff[W-1] == s0_b_ff[W-1] && sum[W-1] != s0_a_ff[W-1])
               tag_in.err = ERR_OVERFLOW;
            else
               tag_in.res = sum;
         end
         OP_SUB: begin
            if (s0_a_ff[W-1] != s0_b_ff[W-1] && dif[W-1] != s0_a_ff[W-1])
               tag_in.err = ERR_OVERFLOW;
            else
               tag_in.res = dif;
         end
         OP_MUL, OP_DIV, OP_MOD: tag_in.res = '0;
         OP_SHL, OP_SHR: begin
            if (s0_b_ff[W-1] || (s0_b_ff > W'(W - 1)))
               tag_in.err = ERR_SHIFT;
            else if (s0_op_ff == OP_SHL)
               tag_in.res = s0_a_ff << s0_b_ff[SHW-1:0];
            else
               tag_in.res = W'($signed(s0_a_ff) >>> s0_b_ff[SHW-1:0]);
         end
         OP_AND:  tag_in.res = s0_a_ff & s0_b_ff;
         OP_XOR:  tag_in.res = s0_a_ff ^ s0_b_ff;
         OP_OR:   tag_in.res = s0_a_ff | s0_b_ff;
         OP_LAND: tag_in.res = W'(s0_a_ff[0] & s0_b_ff[0]);
         OP_LOR:  tag_in.res = W'(s0_a_ff[0] | s0_b_ff[0]);
         default: tag_in.err = ERR_OPCODE;
      endcase
   end

   always_ff @(posedge clock) begin
      tag_ff[0] <= tag_in;
      for (int i = 1; i <= W; i++) tag_ff[i] <= tag_ff[i-1];
      mul_ff[0] <= {mul_ovf, mul_res};
      for (int i = 1; i < MDLY; i++) mul_ff[i] <= mul_ff[i-1];
   end

   // merge divider, multiplier and tag results; zero the result on error
   always_comb begin
      tg      = tag_ff[W];
      fin_res = tg.res;
      fin_err = tg.err;
      case (tg.op)
         OP_MUL: begin
            fin_res = mul_ff[MDLY-1][W-1:0];
            fin_err = mul_ff[MDLY-1][W] ? ERR_OVERFLOW : ERR_OK;
         end
         OP_DIV: begin
            if (tg.dz)
               fin_err = ERR_DIVZERO;
            else if (!tg.neg_q && quo[W-1])
               fin_err = ERR_OVERFLOW;
            else
               fin_res = tg.neg_q ? (~quo + 1'b1) : quo;
         end
         OP_MOD: begin
            if (tg.dz)
               fin_err = ERR_DIVZERO;
            else
               fin_res = tg.neg_r ? (~rmd + 1'b1) : rmd;
         end
         default: begin
            fin_res = tg.res;
            fin_err = tg.err;
         end
      endcase
      if (fin_err != ERR_OK) fin_res = '0;
   end

   always_ff @(posedge clock) begin
      rsp_res_ff <= 64'($signed(fin_res));
      rsp_err_ff <= fin_err;
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_result_value = rsp_res_ff;
   assign rsp_error_code   = rsp_err_ff;

endmodule
`default_nettype wire

>>> hw/rtl/cia_checker.sv
`default_nettype none
module cia_checker import cia_pkg::*; #(
   parameter int DATA_WIDTH = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic        busy,
   input  wire logic [4:0]  req_opcode,
   input  wire logic        rsp_strobe,
   input  wire logic [63:0] rsp_result_value,
   input  wire logic [2:0]  rsp_error_code
);

   localparam int LAT = DATA_WIDTH + 3;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##LAT rsp_strobe)
      else $error("result missing");

   a_bad_op: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_opcode > OP_LOR || (req_opcode > OP_SHR && req_opcode < OP_AND))
      |-> ##LAT rsp_error_code == ERR_OPCODE)
      else $error("invalid opcode not reported");

   a_zero_on_err: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_error_code != ERR_OK |-> rsp_result_value == 64'd0)
      else $error("nonzero result with error");

   a_err_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_error_code <= ERR_OPCODE)
      else $error("bad error code");

   a_reset: assert property (@(posedge clock) reset |=> !rsp_strobe)
      else $error("strobe after reset");

endmodule

bind checked_integer_alu cia_checker #(.DATA_WIDTH(DATA_WIDTH)) u_cia_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .req_opcode       (req_opcode),
   .rsp_strobe       (rsp_strobe),
   .rsp_result_value (rsp_result_value),
   .rsp_error_code   (rsp_error_code)
);
`default_nettype wire

>>> test/checked_integer_alu_checker.sv
module checked_integer_alu_checker import cia_pkg::*; #(
   parameter int DATA_WIDTH = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic               busy,
   input  wire logic        [4:0]  req_opcode,
   input  wire logic signed [63:0] req_lhs_value,
   input  wire logic signed [63:0] req_rhs_value,
   input  wire logic               rsp_strobe,
   input  wire logic signed [63:0] rsp_result_value,
   input  wire logic        [2:0]  rsp_error_code,
   output int                      failures,
   output int                      pending
);

   typedef struct packed {
      logic [63:0] value;
      error_type   code;
   } alu_result_type;

   alu_result_type expected_results[$];

   function automatic logic [63:0] to_word(input logic [63:0] x);
      logic [63:0] m;
      m = {64{1'b1}} >> (64 - DATA_WIDTH);
      x = x & m;
      if (x[DATA_WIDTH-1])
         x = x | ~m;
      return x;
   endfunction

   function automatic alu_result_type compute_alu(input opcode_type op,
                                                  input logic [63:0] lhs_in,
                                                  input logic [63:0] rhs_in);
      logic signed [63:0] a, b;
      logic signed [129:0] exact;
      logic signed [129:0] max_pos, min_neg;
      logic [63:0] ua, ub;
      alu_result_type res;
      a = to_word(lhs_in);
      b = to_word(rhs_in);
      max_pos = (130'sd1 <<< (DATA_WIDTH - 1)) - 130'sd1;
      min_neg = -(130'sd1 <<< (DATA_WIDTH - 1));
      res.value = '0;
      res.code = ERR_OK;
      ua = a[63] ? -a : a;
      ub = b[63] ? -b : b;
      case (op)
         OP_ADD, OP_SUB, OP_MUL: begin
            if (op == OP_ADD)
               exact = 130'(a) + 130'(b);
            else if (op == OP_SUB)
               exact = 130'(a) - 130'(b);
            else
               exact = 130'(a) * 130'(b);
            if (exact > max_pos || exact < min_neg)
               res.code = ERR_OVERFLOW;
            else
               res.value = exact[63:0];
         end
         OP_DIV, OP_MOD: begin
            if (b == 0)
               res.code = ERR_DIVZERO;
            else if (op == OP_DIV) begin
               exact = (a[63] != b[63]) ? -130'(ua / ub) : 130'(ua / ub);
               if (exact > max_pos)
                  res.code = ERR_OVERFLOW;
               else
                  res.value = exact[63:0];
            end else
               res.value = a[63] ? -(ua % ub) : (ua % ub);
         end
         OP_SHL, OP_SHR: begin
            if (b < 0 || b > DATA_WIDTH - 1)
               res.code = ERR_SHIFT;
            else if (op == OP_SHL)
               res.value = a << b[5:0];
            else
               res.value = a >>> b[5:0];
         end
         OP_AND:  res.value = a & b;
         OP_XOR:  res.value = a ^ b;
         OP_OR:   res.value = a | b;
         OP_LAND: res.value = {63'd0, a[0] & b[0]};
         OP_LOR:  res.value = {63'd0, a[0] | b[0]};
         default: res.code = ERR_OPCODE;
      endcase
      if (res.code != ERR_OK)
         res.value = '0;
      res.value = to_word(res.value);
      return res;
   endfunction

   initial failures = 0;
   initial pending = 0;

   always @(posedge clock) begin
      alu_result_type exp_res;
      int errs;
      errs = 0;
      if (!reset) begin
         if (rsp_strobe) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result value=%h code=%0d", $time,
                        rsp_result_value, rsp_error_code);
               errs = errs + 1;
            end else begin
               exp_res = expected_results.pop_front();
               if (rsp_result_value !== exp_res.value) begin
                  $display("%0t: value expected %h actual %h", $time,
                           exp_res.value, rsp_result_value);
                  errs = errs + 1;
               end
               if (rsp_error_code !== exp_res.code) begin
                  $display("%0t: error code expected %0d actual %0d", $time,
                           exp_res.code, rsp_error_code);
                  errs = errs + 1;
               end
            end
         end
         if (start && !busy)
            expected_results.push_back(compute_alu(req_opcode, req_lhs_value,
                                                   req_rhs_value));
      end
      if (errs != 0)
         failures <= failures + errs;
      pending <= expected_results.size();
   end

endmodule

>>> test/checked_integer_alu_test.sv
module checked_integer_alu_test import cia_pkg::*;;

   localparam int DATA_WIDTH = 64;
   localparam int CYCLE_LIMIT = 200000;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic        [4:0]  req_opcode;
   logic signed [63:0] req_lhs_value;
   logic signed [63:0] req_rhs_value;
   logic               rsp_strobe;
   logic signed [63:0] rsp_result_value;
   logic        [2:0]  rsp_error_code;
   int                 failures;
   int                 pending;
   int                 cycles;

   localparam logic [63:0] MIN_VAL = 64'h8000_0000_0000_0000;
   localparam logic [63:0] MAX_VAL = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] NEG_ONE = '1;

   checked_integer_alu #(.DATA_WIDTH(DATA_WIDTH)) dut (.*);

   checked_integer_alu_checker #(.DATA_WIDTH(DATA_WIDTH)) alu_checker (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   initial cycles = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic logic [63:0] random_operand();
      case ($urandom_range(0, 7))
         0: return MIN_VAL;
         1: return MAX_VAL;
         2: return NEG_ONE;
         3: return 64'(signed'($urandom_range(0, 20)) - 10);
         4: return {32'd0, $urandom()};
         5: return {{32{1'b1}}, $urandom()};
         default: return {$urandom(), $urandom()};
      endcase
   endfunction

   task automatic send_item(input opcode_type op, input logic [63:0] lhs,
                            input logic [63:0] rhs);
      int gap;
      start <= 1'b1;
      req_opcode <= op;
      req_lhs_value <= lhs;
      req_rhs_value <= rhs;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   initial begin
      opcode_type op;
      logic [63:0] lhs, rhs;
      reset = 1'b1;
      start = 1'b0;
      req_opcode = '0;
      req_lhs_value = '0;
      req_rhs_value = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_item(OP_ADD, MAX_VAL, 64'd1);
      send_item(OP_ADD, MIN_VAL, NEG_ONE);
      send_item(OP_SUB, MIN_VAL, 64'd1);
      send_item(OP_SUB, 64'd5, MAX_VAL);
      send_item(OP_MUL, MIN_VAL, NEG_ONE);
      send_item(OP_MUL, 64'h4000_0000_0000_0000, NEG_ONE - 1);
      send_item(OP_MUL, 64'h1_0000_0000, 64'h8000_0000);
      send_item(OP_DIV, 64'd7, 64'd0);
      send_item(OP_MOD, MIN_VAL, 64'd0);
      send_item(OP_DIV, MIN_VAL, NEG_ONE);
      send_item(OP_MOD, MIN_VAL, NEG_ONE);
      send_item(OP_DIV, -64'sd7, 64'd2);
      send_item(OP_MOD, -64'sd7, 64'd2);
      send_item(OP_MOD, 64'd7, -64'sd2);
      send_item(OP_SHL, MAX_VAL, 64'd63);
      send_item(OP_SHR, MIN_VAL, 64'd63);
      send_item(OP_SHL, 64'd1, 64'd64);
      send_item(OP_SHR, 64'd1, NEG_ONE);
      send_item(OP_AND, MIN_VAL, NEG_ONE);
      send_item(OP_XOR, MAX_VAL, NEG_ONE);
      send_item(OP_OR, MIN_VAL, MAX_VAL);
      send_item(OP_LAND, NEG_ONE, 64'd3);
      send_item(OP_LOR, 64'd2, 64'd4);
      send_item(opcode_type'(9), 64'd1, 64'd1);
      send_item(opcode_type'(31), 64'd1, 64'd1);

      repeat (450) begin
         if ($urandom_range(0, 9) == 0)
            op = opcode_type'($urandom_range(0, 31));
         else
            case ($urandom_range(0, 11))
               0: op = OP_ADD;  1: op = OP_SUB;  2: op = OP_MUL;
               3: op = OP_DIV;  4: op = OP_MOD;  5: op = OP_SHL;
               6: op = OP_SHR;  7: op = OP_AND;  8: op = OP_XOR;
               9: op = OP_OR;   10: op = OP_LAND; default: op = OP_LOR;
            endcase
         lhs = random_operand();
         rhs = random_operand();
         if ((op == OP_SHL || op == OP_SHR) && $urandom_range(0, 3) != 0)
            rhs = 64'($urandom_range(0, 63));
         if (op == OP_MUL && $urandom_range(0, 1) == 0) begin
            lhs = 64'(signed'($urandom()));
            rhs = 64'(signed'($urandom()));
         end
         send_item(op, lhs, rhs);
      end
      start <= 1'b0;

      while (pending != 0)
         @(posedge clock);
      repeat (DATA_WIDTH + 10) @(posedge clock);
      if (failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

>>> sim.f
hw/rtl/cia_pkg.sv
hw/rtl/cia_divider.sv
hw/rtl/cia_multiplier.sv
hw/rtl/checked_integer_alu.sv
hw/rtl/cia_checker.sv
test/checked_integer_alu_checker.sv
test/checked_integer_alu_test.sv
